FILE: rtl/core/kufe_pkg.sv
// kufe_pkg: shared types and constants for the union-find edge engine
// no dependencies; imported by kufe_tables and kruskal_union_find_edge_engine
`timescale 1ns / 1ps

package kufe_pkg;

  // fixed field widths
  localparam int NODE_W   = 10;
  localparam int WEIGHT_W = 32;
  localparam int SUM_W    = 40;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_WALK_A,
    ST_WALK_B,
    ST_SIZE_A,
    ST_SIZE_B,
    ST_ACCUM,
    ST_DONE
  } kufe_state_t;

  // write strobes towards the tables
  typedef struct packed {
    logic par_we;
    logic sz_we;
  } tbl_wr_t;

endpackage

FILE: rtl/core/kufe_tables.sv
// kufe_tables: parent and set-size memories, one write and one read port each
// depends on kufe_pkg; read data is registered, so it appears in the cycle after the address
`timescale 1ns / 1ps

module kufe_tables
  import kufe_pkg::*;
#(
  parameter int NODE_COUNT = 1024,
  localparam int IDX_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1,
  localparam int SZ_W  = $clog2(NODE_COUNT + 1)
) (
  input  logic             clk,
  input  tbl_wr_t          wr,
  input  logic [IDX_W-1:0] par_waddr,
  input  logic [IDX_W-1:0] par_wdata,
  input  logic [IDX_W-1:0] par_raddr,
  output logic [IDX_W-1:0] par_rdata,
  input  logic [IDX_W-1:0] sz_waddr,
  input  logic [SZ_W-1:0]  sz_wdata,
  input  logic [IDX_W-1:0] sz_raddr,
  output logic [SZ_W-1:0]  sz_rdata
);

  logic [IDX_W-1:0] par_mem [NODE_COUNT];
  logic [SZ_W-1:0]  sz_mem  [NODE_COUNT];

  // parent table
  always_ff @(posedge clk) begin
    if (wr.par_we) begin
      par_mem[par_waddr] <= par_wdata;
    end
    par_rdata <= par_mem[par_raddr];
  end

  // set-size table
  always_ff @(posedge clk) begin
    if (wr.sz_we) begin
      sz_mem[sz_waddr] <= sz_wdata;
    end
    sz_rdata <= sz_mem[sz_raddr];
  end

endmodule

FILE: rtl/core/kruskal_union_find_edge_engine.sv
// kruskal_union_find_edge_engine: union by size over a parent table, running edge total
// depends on kufe_pkg and kufe_tables
//
//   channel | direction | ports
//   in      | input     | in_valid/in_ready, action, new_case, node_a, node_b, weight, last_edge
//   out     | output    | out_valid/out_ready, merged, total_length, saturated, final_res
//
// an accepted edge goes through start, a walk from node_a to its root, a walk from node_b,
// two size reads with the link, the accumulation and the output load; each hop is one
// parent read through the single table port. a link that joins skips the accumulation, an
// item whose ends share a root skips sizes, link and accumulation, and an out of range item
// skips the walks too; union by size keeps root depth within 10 here. a new_case item first
// runs the clearing sweep over all NODE_COUNT entries, and after reset the same sweep runs
// before in_ready rises. a finished result waits in the output register while the next item is taken.
`timescale 1ns / 1ps

module kruskal_union_find_edge_engine
  import kufe_pkg::*;
#(
  parameter int NODE_COUNT = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_action,
  input  logic                in_new_case,
  input  logic [NODE_W-1:0]   in_node_a,
  input  logic [NODE_W-1:0]   in_node_b,
  input  logic [WEIGHT_W-1:0] in_weight,
  input  logic                in_last_edge,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_merged,
  output logic [SUM_W-1:0]    out_total_length,
  output logic                out_saturated,
  output logic                out_final_res
);

  localparam int IDX_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int SZ_W  = $clog2(NODE_COUNT + 1);
  localparam int ADD_W = SUM_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODE_COUNT - 1);

  kufe_state_t state_r, state_nxt;

  logic [IDX_W-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic                clr_item_r, clr_item_nxt;
  logic                action_r, action_nxt;
  logic                last_r, last_nxt;
  logic                in_range_r, in_range_nxt;
  logic [WEIGHT_W-1:0] weight_r, weight_nxt;
  logic [IDX_W-1:0]    na_r, na_nxt;
  logic [IDX_W-1:0]    nb_r, nb_nxt;
  logic [IDX_W-1:0]    cur_r, cur_nxt;
  logic [IDX_W-1:0]    ra_r, ra_nxt;
  logic [IDX_W-1:0]    rb_r, rb_nxt;
  logic [SZ_W-1:0]     sza_r, sza_nxt;
  logic                merged_r, merged_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic                clip_r, clip_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_merged_r, out_merged_nxt;
  logic [SUM_W-1:0]    out_total_r, out_total_nxt;
  logic                out_sat_r, out_sat_nxt;
  logic                out_final_r, out_final_nxt;

  tbl_wr_t          tbl_wr;
  logic [IDX_W-1:0] par_waddr, par_wdata, par_raddr, par_rdata;
  logic [IDX_W-1:0] sz_waddr, sz_raddr;
  logic [SZ_W-1:0]  sz_wdata, sz_rdata;

  // shared adder: set sizes while linking, running total while accumulating
  logic [ADD_W-1:0] add_a, add_b, add_sum;
  assign add_sum = add_a + add_b;

  kufe_tables #(
    .NODE_COUNT(NODE_COUNT)
  ) u_tables (
    .clk       (clk),
    .wr        (tbl_wr),
    .par_waddr (par_waddr),
    .par_wdata (par_wdata),
    .par_raddr (par_raddr),
    .par_rdata (par_rdata),
    .sz_waddr  (sz_waddr),
    .sz_wdata  (sz_wdata),
    .sz_raddr  (sz_raddr),
    .sz_rdata  (sz_rdata)
  );

  assign in_ready         = (state_r == ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_merged       = out_merged_r;
  assign out_total_length = out_total_r;
  assign out_saturated    = out_sat_r;
  assign out_final_res    = out_final_r;

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      clr_item_r  <= 1'b0;
      sum_r       <= '0;
      clip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_item_r  <= clr_item_nxt;
      sum_r       <= sum_nxt;
      clip_r      <= clip_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    action_r     <= action_nxt;
    last_r       <= last_nxt;
    in_range_r   <= in_range_nxt;
    weight_r     <= weight_nxt;
    na_r         <= na_nxt;
    nb_r         <= nb_nxt;
    cur_r        <= cur_nxt;
    ra_r         <= ra_nxt;
    rb_r         <= rb_nxt;
    sza_r        <= sza_nxt;
    merged_r     <= merged_nxt;
    out_merged_r <= out_merged_nxt;
    out_total_r  <= out_total_nxt;
    out_sat_r    <= out_sat_nxt;
    out_final_r  <= out_final_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    clr_item_nxt   = clr_item_r;
    action_nxt     = action_r;
    last_nxt       = last_r;
    in_range_nxt   = in_range_r;
    weight_nxt     = weight_r;
    na_nxt         = na_r;
    nb_nxt         = nb_r;
    cur_nxt        = cur_r;
    ra_nxt         = ra_r;
    rb_nxt         = rb_r;
    sza_nxt        = sza_r;
    merged_nxt     = merged_r;
    sum_nxt        = sum_r;
    clip_nxt       = clip_r;
    out_valid_nxt  = out_valid_r;
    out_merged_nxt = out_merged_r;
    out_total_nxt  = out_total_r;
    out_sat_nxt    = out_sat_r;
    out_final_nxt  = out_final_r;

    tbl_wr    = '0;
    par_waddr = clr_cnt_r;
    par_wdata = clr_cnt_r;
    par_raddr = cur_r;
    sz_waddr  = clr_cnt_r;
    sz_wdata  = SZ_W'(1);
    sz_raddr  = ra_r;
    add_a     = {1'b0, sum_r};
    add_b     = ADD_W'(weight_r);

    // result handed over downstream
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      // sweep tables back to identity and size one, then apply a waiting item
      ST_CLEAR: begin
        tbl_wr.par_we = 1'b1;
        tbl_wr.sz_we  = 1'b1;
        clr_cnt_nxt   = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_IDX) begin
          clr_cnt_nxt  = '0;
          clr_item_nxt = 1'b0;
          state_nxt    = clr_item_r ? ST_START : ST_IDLE;
        end
      end

      // take a new item
      ST_IDLE: begin
        if (in_valid) begin
          action_nxt   = in_action;
          last_nxt     = in_last_edge;
          weight_nxt   = in_weight;
          na_nxt       = IDX_W'(in_node_a);
          nb_nxt       = IDX_W'(in_node_b);
          in_range_nxt = (32'(in_node_a) < NODE_COUNT) && (32'(in_node_b) < NODE_COUNT);
          merged_nxt   = 1'b0;
          state_nxt    = ST_START;
          if (in_new_case) begin
            sum_nxt      = '0;
            clip_nxt     = 1'b0;
            clr_item_nxt = 1'b1;
            state_nxt    = ST_CLEAR;
          end
        end
      end

      // begin the walk from node a, or skip an out of range item
      ST_START: begin
        clr_cnt_nxt = '0;
        if (in_range_r) begin
          par_raddr = na_r;
          cur_nxt   = na_r;
          state_nxt = ST_WALK_A;
        end else begin
          state_nxt = ST_DONE;
        end
      end

      // follow parents of node a up to its root
      ST_WALK_A: begin
        if (par_rdata == cur_r) begin
          ra_nxt    = cur_r;
          par_raddr = nb_r;
          cur_nxt   = nb_r;
          state_nxt = ST_WALK_B;
        end else begin
          par_raddr = par_rdata;
          cur_nxt   = par_rdata;
        end
      end

      // follow parents of node b, then fetch the size of root a
      ST_WALK_B: begin
        if (par_rdata == cur_r) begin
          rb_nxt = cur_r;
          if (cur_r == ra_r) begin
            state_nxt = ST_DONE;
          end else begin
            sz_raddr  = ra_r;
            state_nxt = ST_SIZE_A;
          end
        end else begin
          par_raddr = par_rdata;
          cur_nxt   = par_rdata;
        end
      end

      // hold size of root a, fetch size of root b
      ST_SIZE_A: begin
        sza_nxt   = sz_rdata;
        sz_raddr  = rb_r;
        state_nxt = ST_SIZE_B;
      end

      // link the smaller root under the larger; ties go to root a
      ST_SIZE_B: begin
        add_a         = ADD_W'(sza_r);
        add_b         = ADD_W'(sz_rdata);
        tbl_wr.par_we = 1'b1;
        tbl_wr.sz_we  = 1'b1;
        sz_wdata      = SZ_W'(add_sum);
        if (sza_r >= sz_rdata) begin
          par_waddr = rb_r;
          par_wdata = ra_r;
          sz_waddr  = ra_r;
        end else begin
          par_waddr = ra_r;
          par_wdata = rb_r;
          sz_waddr  = rb_r;
        end
        merged_nxt = 1'b1;
        state_nxt  = action_r ? ST_ACCUM : ST_DONE;
      end

      // add the edge weight, clipping at full scale
      ST_ACCUM: begin
        if (add_sum[SUM_W]) begin
          sum_nxt  = SUM_MAX;
          clip_nxt = 1'b1;
        end else begin
          sum_nxt = add_sum[SUM_W-1:0];
        end
        state_nxt = ST_DONE;
      end

      // load the output register once it is free
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_merged_nxt = merged_r;
          out_total_nxt  = sum_r;
          out_sat_nxt    = clip_r;
          out_final_nxt  = last_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: bench/kruskal_union_find_edge_engine_tb.sv
// kruskal_union_find_edge_engine_tb: self-checking bench for the union-find edge engine
// depends on kufe_pkg and kruskal_union_find_edge_engine; predicts each result from its own
// copy of the parent and size tables and checks every item in order under random flow control
`timescale 1ns / 1ps

module kruskal_union_find_edge_engine_tb;
  import kufe_pkg::*;

  localparam int NODE_COUNT   = 1024;
  localparam int CLK_PERIOD   = 12;
  localparam int ITEM_TARGET  = 700;
  localparam int LIMIT_CYCLES = 800_000;
  localparam int HOLD_CYCLES  = 500;
  localparam int HOLD_AFTER   = 60;
  localparam int DRAIN_CYCLES = 100;
  localparam int PRINT_CAP    = 100;

  localparam logic ACT_LINK = 1'b0;
  localparam logic ACT_EDGE = 1'b1;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {WEIGHT_W{1'b1}};

  typedef enum logic [1:0] {RX_FLOW, RX_RANDOM, RX_STALL} rx_mode_t;

  typedef struct {
    logic                action;
    logic                new_case;
    logic [NODE_W-1:0]   node_a;
    logic [NODE_W-1:0]   node_b;
    logic [WEIGHT_W-1:0] weight;
    logic                last_edge;
  } edge_item_t;

  typedef struct {
    logic             merged;
    logic [SUM_W-1:0] total;
    logic             saturated;
    logic             final_res;
  } mst_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_action = 1'b0;
  logic in_new_case = 1'b0;
  logic [NODE_W-1:0] in_node_a = '0;
  logic [NODE_W-1:0] in_node_b = '0;
  logic [WEIGHT_W-1:0] in_weight = '0;
  logic in_last_edge = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_merged;
  logic [SUM_W-1:0] out_total_length;
  logic out_saturated;
  logic out_final_res;

  kruskal_union_find_edge_engine #(
    .NODE_COUNT(NODE_COUNT)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_new_case      (in_new_case),
    .in_node_a        (in_node_a),
    .in_node_b        (in_node_b),
    .in_weight        (in_weight),
    .in_last_edge     (in_last_edge),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_merged       (out_merged),
    .out_total_length (out_total_length),
    .out_saturated    (out_saturated),
    .out_final_res    (out_final_res)
  );

  // predicted forest and running total
  logic [NODE_W-1:0] parent_of [0:NODE_COUNT-1];
  int unsigned       set_size  [0:NODE_COUNT-1];
  logic [SUM_W-1:0]  length_acc;
  logic              length_clipped;

  edge_item_t  pending_edges[$];
  mst_result_t awaited_results[$];
  int fail_count = 0;
  int results_seen = 0;

  task automatic report_mismatch(input string msg);
    if (fail_count < PRINT_CAP)
      $display("ERROR @%0t: %s", $time, msg);
    fail_count++;
  endtask

  function automatic void clear_forest();
    for (int i = 0; i < NODE_COUNT; i++) begin
      parent_of[i] = NODE_W'(i);
      set_size[i]  = 1;
    end
    length_acc     = '0;
    length_clipped = 1'b0;
  endfunction

  function automatic logic [NODE_W-1:0] root_of_node(input logic [NODE_W-1:0] n);
    logic [NODE_W-1:0] cur;
    int hops;
    cur  = n;
    hops = 0;
    while (parent_of[cur] != cur && hops < NODE_COUNT) begin
      cur = parent_of[cur];
      hops++;
    end
    return cur;
  endfunction

  // union by size, first root wins a tie; accepted edges add to the clipped total
  function automatic mst_result_t apply_edge(input edge_item_t it);
    mst_result_t r;
    logic [NODE_W-1:0] ra;
    logic [NODE_W-1:0] rb;
    logic [SUM_W:0] wide_sum;
    r.merged = 1'b0;
    if (it.new_case)
      clear_forest();
    if (int'(it.node_a) < NODE_COUNT && int'(it.node_b) < NODE_COUNT) begin
      ra = root_of_node(it.node_a);
      rb = root_of_node(it.node_b);
      if (ra != rb) begin
        if (set_size[ra] >= set_size[rb]) begin
          set_size[ra] += set_size[rb];
          parent_of[rb] = ra;
        end else begin
          set_size[rb] += set_size[ra];
          parent_of[ra] = rb;
        end
        r.merged = 1'b1;
        if (it.action == ACT_EDGE) begin
          wide_sum = {1'b0, length_acc} + {{(SUM_W+1-WEIGHT_W){1'b0}}, it.weight};
          if (wide_sum > {1'b0, SUM_MAX}) begin
            length_acc     = SUM_MAX;
            length_clipped = 1'b1;
          end else begin
            length_acc = wide_sum[SUM_W-1:0];
          end
        end
      end
    end
    r.total     = length_acc;
    r.saturated = length_clipped;
    r.final_res = it.last_edge;
    return r;
  endfunction

  task automatic add_item(input logic act, input logic nc, input logic [NODE_W-1:0] a,
                          input logic [NODE_W-1:0] b, input logic [WEIGHT_W-1:0] w,
                          input logic last);
    edge_item_t it;
    it.action    = act;
    it.new_case  = nc;
    it.node_a    = a;
    it.node_b    = b;
    it.weight    = w;
    it.last_edge = last;
    pending_edges.push_back(it);
  endtask

  function automatic logic [WEIGHT_W-1:0] rand_weight();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return WEIGHT_MAX;
      2:       return WEIGHT_W'($urandom_range(0, 255));
      default: return WEIGHT_W'($urandom);
    endcase
  endfunction

  // clock
  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // reset
  initial begin
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  // item list: directed start, then random cases, one long saturating case and noise
  initial begin
    int span;
    int base;
    int len;
    int tip;
    bit skip_clear;
    bit sat_done;
    logic last;
    clear_forest();

    add_item(ACT_EDGE, 1'b1, 10'd0, 10'h3FF, WEIGHT_MAX, 1'b0);
    add_item(ACT_EDGE, 1'b0, 10'h3FF, 10'd0, 32'd1, 1'b0);
    add_item(ACT_EDGE, 1'b0, 10'd5, 10'd5, 32'd7, 1'b0);
    add_item(ACT_LINK, 1'b0, 10'd2, 10'd3, 32'hDEADBEEF, 1'b0);
    add_item(ACT_LINK, 1'b0, 10'd3, 10'd2, 32'd9, 1'b0);
    // equal sizes: root of node_a takes over
    add_item(ACT_EDGE, 1'b0, 10'd2, 10'd0, 32'd0, 1'b0);
    add_item(ACT_EDGE, 1'b0, 10'd4, 10'h3FF, 32'h80000000, 1'b0);
    add_item(ACT_EDGE, 1'b0, 10'd512, 10'd511, 32'h00000100, 1'b0);
    add_item(ACT_LINK, 1'b0, 10'h3FF, 10'd512, WEIGHT_MAX, 1'b0);
    add_item(ACT_EDGE, 1'b0, 10'd0, 10'd511, WEIGHT_MAX, 1'b0);
    add_item(ACT_EDGE, 1'b0, 10'h2AA, 10'h155, 32'h55555555, 1'b0);
    add_item(ACT_EDGE, 1'b0, 10'h155, 10'h3FF, 32'hAAAAAAAA, 1'b1);
    add_item(ACT_LINK, 1'b1, 10'd0, 10'd1, 32'h12345678, 1'b0);
    add_item(ACT_EDGE, 1'b0, 10'd1, 10'd0, WEIGHT_MAX, 1'b0);
    add_item(ACT_EDGE, 1'b1, 10'h3FF, 10'h3FF, WEIGHT_MAX, 1'b1);
    add_item(ACT_EDGE, 1'b0, 10'd10, 10'd11, WEIGHT_MAX, 1'b0);
    add_item(ACT_EDGE, 1'b1, 10'd7, 10'd8, 32'd0, 1'b1);

    sat_done = 1'b0;
    while (pending_edges.size() < ITEM_TARGET) begin
      if (!sat_done && pending_edges.size() > 250) begin
        // long chain of near-maximum edges drives the total past its ceiling
        sat_done = 1'b1;
        base = $urandom_range(0, NODE_COUNT - 300);
        tip  = base;
        for (int k = 0; k < 320; k++) begin
          last = (k == 319);
          if (k % 7 == 6) begin
            add_item(ACT_EDGE, 1'b0, NODE_W'(base), NODE_W'(tip), WEIGHT_MAX, last);
          end else begin
            add_item(ACT_EDGE, k == 0, NODE_W'(tip), NODE_W'(tip + 1),
                     WEIGHT_MAX - WEIGHT_W'($urandom_range(0, 3)), last);
            tip++;
          end
        end
      end else if ($urandom_range(0, 9) == 0) begin
        // noise
        repeat ($urandom_range(1, 6))
          add_item(1'($urandom_range(0, 1)), $urandom_range(0, 15) == 0,
                   NODE_W'($urandom_range(0, NODE_COUNT - 1)),
                   NODE_W'($urandom_range(0, NODE_COUNT - 1)),
                   WEIGHT_W'($urandom), 1'($urandom_range(0, 1)));
      end else begin
        // one case over a random window of nodes, sometimes left without its clear
        case ($urandom_range(0, 3))
          0:       span = $urandom_range(2, 8);
          3:       span = $urandom_range(65, NODE_COUNT);
          default: span = $urandom_range(9, 64);
        endcase
        base = $urandom_range(0, NODE_COUNT - span);
        len = $urandom_range(4, 40);
        skip_clear = ($urandom_range(0, 5) == 0);
        for (int k = 0; k < len; k++) begin
          if (k == len - 1)
            last = ($urandom_range(0, 7) != 0);
          else
            last = ($urandom_range(0, 19) == 0);
          add_item(($urandom_range(0, 5) == 0) ? ACT_LINK : ACT_EDGE,
                   (k == 0) && !skip_clear,
                   NODE_W'(base + $urandom_range(0, span - 1)),
                   NODE_W'(base + $urandom_range(0, span - 1)),
                   rand_weight(), last);
        end
      end
    end
  end

  // driver: bursts of items with random gaps, prediction on each accepted item
  edge_item_t cur_item;
  int burst_left = 1;
  int gap_left = 0;
  mst_result_t predicted;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predicted = apply_edge(cur_item);
        awaited_results.push_back(predicted);
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_edges.size() > 0) begin
          cur_item = pending_edges.pop_front();
          in_action    <= cur_item.action;
          in_new_case  <= cur_item.new_case;
          in_node_a    <= cur_item.node_a;
          in_node_b    <= cur_item.node_b;
          in_weight    <= cur_item.weight;
          in_last_edge <= cur_item.last_edge;
          in_valid     <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 30);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: flow, random and stall stretches, plus one long hold-off
  rx_mode_t rx_mode = RX_FLOW;
  int rx_run = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int rx_pick;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      if (rx_run == 0) begin
        rx_pick = $urandom_range(0, 3);
        rx_mode = (rx_pick < 2) ? RX_FLOW : ((rx_pick == 2) ? RX_RANDOM : RX_STALL);
        rx_run  = $urandom_range(2, 40);
      end else begin
        rx_run--;
      end
      case (rx_mode)
        RX_FLOW:   out_ready <= 1'b1;
        RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
        default:   out_ready <= 1'b0;
      endcase
    end
  end

  // monitor: each result against the oldest prediction
  mst_result_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (awaited_results.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        want = awaited_results.pop_front();
        if (out_merged !== want.merged)
          report_mismatch($sformatf("merged %0b, want %0b", out_merged, want.merged));
        if (out_total_length !== want.total)
          report_mismatch($sformatf("total_length %0h, want %0h",
                                    out_total_length, want.total));
        if (out_saturated !== want.saturated)
          report_mismatch($sformatf("saturated %0b, want %0b",
                                    out_saturated, want.saturated));
        if (out_final_res !== want.final_res)
          report_mismatch($sformatf("final_res %0b, want %0b",
                                    out_final_res, want.final_res));
      end
    end
  end

  // end of run once every item has gone through
  initial begin
    @(posedge rst_n);
    do @(negedge clk);
    while (pending_edges.size() != 0 || in_valid || awaited_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("kruskal_union_find_edge_engine_tb passed");
    else
      $display("kruskal_union_find_edge_engine_tb failed");
    $finish;
  end

  // watchdog
  initial begin
    #(longint'(LIMIT_CYCLES) * CLK_PERIOD);
    $display("kruskal_union_find_edge_engine_tb failed");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/kufe_pkg.sv
rtl/core/kufe_tables.sv
rtl/core/kruskal_union_find_edge_engine.sv
bench/kruskal_union_find_edge_engine_tb.sv
